// File: rtl/assert_macros.svh
// Assertion macros used by the reorder buffer back module.
// The module that uses them provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define IORB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies another in the next cycle.
`define IORB_ASSERT_NEXT(lbl, pre, post, msg) \
  `IORB_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// File: rtl/iorb_pkg.sv
package iorb_pkg;

  // Fixed field widths of the transaction ports.
  localparam int unsigned POS_W = 16;
  localparam int unsigned ID_W  = 32;

  // Defaults for the top level parameters.
  localparam int unsigned DEPTH_DEFAULT   = 16;
  localparam int unsigned ID_BITS_DEFAULT = 32;

  // Entries of the command queue between front and back.
  localparam int unsigned CMDQ_DEPTH = 2;

  // Input kind codes.
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // Result kind codes.
  typedef enum logic [1:0] {
    RES_RELEASE  = 2'd0,
    RES_END      = 2'd1,
    RES_NOT_DONE = 2'd2,
    RES_REJECT   = 2'd3
  } res_kind_e;

  // Command classes decided by the front.
  typedef enum logic [1:0] {
    CMD_STORE  = 2'd0,
    CMD_REJECT = 2'd1,
    CMD_END    = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [POS_W-1:0]  pos;
    logic [ID_W-1:0]   id;
  } cmd_t;

  // Status of the back as seen by the front.
  typedef struct packed {
    logic              busy;
    logic [POS_W-1:0]  head_pos;
  } back_stat_t;

endpackage

// File: rtl/iorb_front.sv
module iorb_front #(
  parameter int unsigned DEPTH = iorb_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [iorb_pkg::POS_W-1:0]  position_i,
  input  logic [iorb_pkg::ID_W-1:0]   item_id_i,
  input  iorb_pkg::back_stat_t        stat_i,
  input  logic                        q_empty_i,
  output logic                        push_o,
  output iorb_pkg::cmd_t              cmd_o
);

  localparam int unsigned PosW = iorb_pkg::POS_W;

  logic                       hold_vld_q;
  logic                       kind_q;
  logic [PosW-1:0]            pos_q;
  logic [iorb_pkg::ID_W-1:0]  id_q;
  logic [PosW-1:0]            pos_dist;

  // A held transaction is classified only once the back has settled, so that
  // the head position it is compared against is final.
  assign push_o     = hold_vld_q && q_empty_i && !stat_i.busy;
  assign in_ready_o = !hold_vld_q || push_o;

  // Hold register for one input transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      kind_q     <= iorb_pkg::KIND_STORE;
      pos_q      <= '0;
      id_q       <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        hold_vld_q <= 1'b1;
        kind_q     <= kind_i;
        pos_q      <= position_i;
        id_q       <= item_id_i;
      end else if (push_o) begin
        hold_vld_q <= 1'b0;
      end
    end
  end

  // Classification: end request, out-of-window rejection or store.
  always_comb begin
    pos_dist  = pos_q - stat_i.head_pos;
    cmd_o.pos = pos_q;
    cmd_o.id  = id_q;
    if (kind_q == iorb_pkg::KIND_END) begin
      cmd_o.op = iorb_pkg::CMD_END;
    end else if (pos_dist >= PosW'(DEPTH)) begin
      cmd_o.op = iorb_pkg::CMD_REJECT;
    end else begin
      cmd_o.op = iorb_pkg::CMD_STORE;
    end
  end

endmodule

// File: rtl/iorb_cmdq.sv
module iorb_cmdq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  iorb_pkg::cmd_t  data_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic            empty_o,
  output iorb_pkg::cmd_t  data_o
);

  localparam int unsigned Depth = iorb_pkg::CMDQ_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  iorb_pkg::cmd_t   buf_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign valid_o = (count_q != '0);
  assign empty_o = (count_q == '0);
  assign data_o  = buf_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/iorb_back.sv
`include "assert_macros.svh"

module iorb_back #(
  parameter int unsigned DEPTH   = iorb_pkg::DEPTH_DEFAULT,
  parameter int unsigned ID_BITS = iorb_pkg::ID_BITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  iorb_pkg::cmd_t              q_cmd_i,
  output logic                        q_pop_o,
  output iorb_pkg::back_stat_t        stat_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  result_kind_o,
  output logic [iorb_pkg::ID_W-1:0]   released_id_o,
  output logic [iorb_pkg::POS_W-1:0]  released_position_o,
  output logic                        last_o
);

  localparam int unsigned PosW = iorb_pkg::POS_W;
  localparam int unsigned IdW  = iorb_pkg::ID_W;
  localparam int unsigned IdxW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_END
  } state_e;

  state_e                 state_q;
  logic [DEPTH-1:0]       slot_full_q;
  logic [ID_BITS-1:0]     slot_mem [DEPTH];
  logic [ID_BITS-1:0]     rd_id_q;
  logic [PosW-1:0]        head_pos_q;
  logic [IdxW-1:0]        head_slot_q;
  logic [PosW-1:0]        recv_q;
  logic                   end_req_q;
  logic                   end_sent_q;

  logic                   out_valid_q;
  iorb_pkg::res_kind_e    out_kind_q;
  logic [IdW-1:0]         out_id_q;
  logic [PosW-1:0]        out_pos_q;
  logic                   out_last_q;

  logic [PosW-1:0]        pos_dist;
  logic [IdxW:0]          idx_sum;
  logic [IdxW-1:0]        st_idx;
  logic [IdxW-1:0]        nxt_slot;
  logic                   dup;
  logic                   store_ok;
  logic                   needs_out;
  logic                   can_emit;
  logic                   drained;
  logic                   fin;
  logic                   mem_we;
  logic                   emit;
  iorb_pkg::res_kind_e    emit_kind;
  logic [IdW-1:0]         emit_id;
  logic [PosW-1:0]        emit_pos;
  logic                   emit_last;

  assign stat_o.busy     = (state_q != ST_IDLE);
  assign stat_o.head_pos = head_pos_q;

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = out_kind_q;
  assign released_id_o       = out_id_q;
  assign released_position_o = out_pos_q;
  assign last_o              = out_last_q;

  // Ring index of the slot addressed by the command and of the slot after
  // the head; the window check in the front keeps the sum below twice DEPTH.
  always_comb begin
    pos_dist = q_cmd_i.pos - head_pos_q;
    idx_sum  = (IdxW+1)'(head_slot_q) + (IdxW+1)'(pos_dist[IdxW-1:0]);
    if (idx_sum >= (IdxW+1)'(DEPTH)) begin
      st_idx = IdxW'(idx_sum - (IdxW+1)'(DEPTH));
    end else begin
      st_idx = idx_sum[IdxW-1:0];
    end
    nxt_slot = (head_slot_q == IdxW'(DEPTH - 1)) ? '0 : head_slot_q + IdxW'(1);
  end

  // Decision for the command at the head of the queue.
  always_comb begin
    can_emit  = !out_valid_q || out_ready_i;
    dup       = slot_full_q[st_idx];
    store_ok  = (q_cmd_i.op == iorb_pkg::CMD_STORE) && !dup;
    needs_out = (q_cmd_i.op == iorb_pkg::CMD_REJECT)
             || ((q_cmd_i.op == iorb_pkg::CMD_STORE) && dup)
             || ((q_cmd_i.op == iorb_pkg::CMD_END) && !end_sent_q);
    q_pop_o   = (state_q == ST_IDLE) && q_valid_i && (!needs_out || can_emit);
    mem_we    = q_pop_o && store_ok;
    drained   = (head_pos_q == recv_q);
    fin       = end_req_q && !end_sent_q && ((head_pos_q + PosW'(1)) == recv_q);
  end

  // Result to be loaded into the output register this cycle.
  always_comb begin
    emit      = 1'b0;
    emit_kind = iorb_pkg::RES_RELEASE;
    emit_id   = '0;
    emit_pos  = head_pos_q;
    emit_last = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (q_pop_o && needs_out) begin
          emit = 1'b1;
          if (q_cmd_i.op == iorb_pkg::CMD_END) begin
            emit_kind = drained ? iorb_pkg::RES_END : iorb_pkg::RES_NOT_DONE;
          end else begin
            emit_kind = iorb_pkg::RES_REJECT;
            emit_pos  = q_cmd_i.pos;
          end
        end
      end
      ST_EMIT: begin
        emit      = can_emit;
        emit_id   = IdW'(rd_id_q);
        emit_last = !slot_full_q[nxt_slot] && !fin;
      end
      ST_END: begin
        emit      = can_emit;
        emit_kind = iorb_pkg::RES_END;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Slot store with a registered read port at the head slot.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[st_idx] <= ID_BITS'(q_cmd_i.id);
    end
    if (state_q == ST_READ) begin
      rd_id_q <= slot_mem[head_slot_q];
    end
  end

  // Drain sequencer, buffer bookkeeping and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_full_q <= '0;
      head_pos_q  <= '0;
      head_slot_q <= '0;
      recv_q      <= '0;
      end_req_q   <= 1'b0;
      end_sent_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= iorb_pkg::RES_RELEASE;
      out_id_q    <= '0;
      out_pos_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        out_kind_q  <= emit_kind;
        out_id_q    <= emit_id;
        out_pos_q   <= emit_pos;
        out_last_q  <= emit_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o && (q_cmd_i.op == iorb_pkg::CMD_END)) begin
            end_req_q <= 1'b1;
            if (!end_sent_q && drained) begin
              end_sent_q <= 1'b1;
            end
          end
          if (mem_we) begin
            slot_full_q[st_idx] <= 1'b1;
            recv_q              <= recv_q + PosW'(1);
            if (st_idx == head_slot_q) begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (can_emit) begin
            slot_full_q[head_slot_q] <= 1'b0;
            head_slot_q              <= nxt_slot;
            head_pos_q               <= head_pos_q + PosW'(1);
            if (slot_full_q[nxt_slot]) begin
              state_q <= ST_READ;
            end else if (fin) begin
              state_q <= ST_END;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_END: begin
          if (can_emit) begin
            end_sent_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The slot being released must hold an item.
  `IORB_ASSERT(a_emit_slot_full, (state_q == ST_EMIT) |-> slot_full_q[head_slot_q], "release of an empty slot")
  // Once sent, the end marker is never sent again.
  `IORB_ASSERT_NEXT(a_end_sent_sticky, end_sent_q, end_sent_q, "end marker flag cleared")
  // The head only moves on a release.
  `IORB_ASSERT(a_head_on_release, (head_pos_q != $past(head_pos_q)) |-> $past(emit && (state_q == ST_EMIT)), "head moved without a release")
  // A store at the head always starts a drain.
  `IORB_ASSERT_NEXT(a_head_store_drains, mem_we && (st_idx == head_slot_q), state_q == ST_READ, "store at head did not start a drain")

endmodule

// File: rtl/in_order_release_reorder_buffer_unit.sv
// In-order release reorder buffer. Items tagged with a 16-bit sequence position
// arrive in any order and are held in DEPTH slots; when the item at the head
// position arrives, it and every consecutive stored item behind it are released
// in sequence order, the last result of each input transaction carrying last_o.
// Positions DEPTH or more past the head, and positions whose slot is already
// occupied, are answered with a rejection. An end request is answered with an
// end marker if everything received has been released, otherwise with "not
// finished", and the end marker then follows the drain that empties the buffer;
// it is sent once only. An input transaction is held in a front register,
// classified once the back has finished the previous one, and passed through a
// two-entry command queue. Each released item passes through the back as a
// registered read of the slot store and then the loading of the output
// register. Rejections and end replies are loaded into the output register
// straight from the idle state. The output register lets the next transaction
// be accepted while a result waits. No clearing pass is needed after reset.
module in_order_release_reorder_buffer_unit #(
  parameter int unsigned DEPTH   = iorb_pkg::DEPTH_DEFAULT,
  parameter int unsigned ID_BITS = iorb_pkg::ID_BITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [iorb_pkg::POS_W-1:0]  position_i,
  input  logic [iorb_pkg::ID_W-1:0]   item_id_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  result_kind_o,
  output logic [iorb_pkg::ID_W-1:0]   released_id_o,
  output logic [iorb_pkg::POS_W-1:0]  released_position_o,
  output logic                        last_o
);

  iorb_pkg::back_stat_t  stat;
  iorb_pkg::cmd_t        push_cmd;
  iorb_pkg::cmd_t        q_cmd;
  logic                  push;
  logic                  pop;
  logic                  q_valid;
  logic                  q_empty;

  // Front: input hold register and classification.
  iorb_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .position_i (position_i),
    .item_id_i  (item_id_i),
    .stat_i     (stat),
    .q_empty_i  (q_empty),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Command queue between front and back.
  iorb_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .valid_o (q_valid),
    .empty_o (q_empty),
    .data_o  (q_cmd)
  );

  // Back: slot store, drain sequencer and output register.
  iorb_back #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_cmd_i             (q_cmd),
    .q_pop_o             (pop),
    .stat_o              (stat),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .result_kind_o       (result_kind_o),
    .released_id_o       (released_id_o),
    .released_position_o (released_position_o),
    .last_o              (last_o)
  );

endmodule
